// ===== sv/tripto_pkg.sv =====
// ----------------------------------------------------------------------------
// Trip timer package
// Item types, event codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tripto_pkg;

    // Event codes carried in the op field.
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_VALID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORED_TRAVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_SPEED        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FUEL_THRESHOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_LIMIT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_INTERVAL     = 3'd7;

    // Register values after reset.
    localparam logic [15:0] STOP_SPEED_RST        = 16'd50;
    localparam logic [15:0] SAVE_SPEED_RST        = 16'd200;
    localparam logic [15:0] FUEL_THRESHOLD_RST    = 16'd10;
    localparam logic [31:0] TIMEOUT_MS_RST        = 32'd7200000;
    localparam logic [31:0] RESTORE_LIMIT_SEC_RST = 32'd7200;
    localparam logic [31:0] SAVE_INTERVAL_MS_RST  = 32'd30000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [15:0] speed;
        logic [15:0] fuel_rate;
        logic [31:0] stand_time_sec;
        logic        stand_time_bad;
    } evt_t;

    typedef struct packed {
        logic        handled;
        logic [31:0] travel_time_ms;
        logic        restored;
        logic        trip_cleared;
        logic        save_stopped;
        logic        save_cleared;
        logic        awaiting_report;
    } res_t;

endpackage

// ===== sv/trip_timer_with_idle_timeout.sv =====
// ----------------------------------------------------------------------------
// Trip timer with idle timeout
// Keeps the travel time of one trip, restores or clears it at start-up and
// clears it after the vehicle has stood idle too long.
// ----------------------------------------------------------------------------
// Usage. Events arrive on the evt channel (evt_valid, evt_stall, evt) and an
// item is taken at a rising edge where evt_valid is high and evt_stall low.
// Every event yields exactly one result item on the res channel (res_valid,
// res_stall, res), taken on the same rule. The result of an event is computed
// in the cycle it is accepted and appears in the output register in the next
// cycle, and one event can be accepted in every cycle while the receiver does
// not stall; the result is set by the single pass through the tick arithmetic
// (one subtract, one add and the wrapped compares) into the result register.
// If the receiver stalls while a result is waiting, evt_stall is raised in
// the same cycle and the waiting result holds; as soon as the result is taken
// a new event is accepted again in that same cycle.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle with no wait; the user must write it only while the block is idle,
// as the block does not enforce this. Reset puts every register but res_reg at
// its reset value, empties the output register and awaits the stand-time report.
// ----------------------------------------------------------------------------
module trip_timer_with_idle_timeout (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                evt_valid,
    output logic                                evt_stall,
    input  tripto_pkg::evt_t                    evt,
    output logic                                res_valid,
    input  logic                                res_stall,
    output tripto_pkg::res_t                    res,
    input  logic                                cfg_we,
    input  logic [tripto_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tripto_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tripto_pkg::*;

    // Configuration registers.
    logic        restore_valid_reg;
    logic [31:0] restored_travel_reg;
    logic [15:0] stop_speed_reg;
    logic [15:0] save_speed_reg;
    logic [15:0] fuel_threshold_reg;
    logic [31:0] timeout_ms_reg;
    logic [31:0] restore_limit_reg;
    logic [31:0] save_interval_reg;

    // Trip state.
    logic        awaiting_reg,      awaiting_next;
    logic [31:0] base_travel_reg,   base_travel_next;
    logic [31:0] session_start_reg, session_start_next;
    logic [31:0] idle_start_reg,    idle_start_next;
    logic [31:0] last_save_reg,     last_save_next;
    logic        stop_saved_reg,    stop_saved_next;
    logic        running_reg,       running_next;
    logic [31:0] travel_now_reg,    travel_now_next;

    // Output register.
    logic        res_valid_reg;
    res_t        res_reg, res_next;

    logic        evt_accept;
    logic        active;
    logic        stopped;
    logic        restore_ok;
    logic [31:0] session_elapsed;
    logic [31:0] idle_eff;
    logic [31:0] idle_elapsed;
    logic [31:0] save_elapsed;

    // The output register frees itself in the cycle its result is taken, so
    // the input only waits while a result is held back by the receiver.
    assign evt_stall  = res_valid_reg & res_stall;
    assign evt_accept = evt_valid & ~evt_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign active     = (evt.speed > stop_speed_reg) || (evt.fuel_rate > fuel_threshold_reg);
    assign stopped    = evt.speed < save_speed_reg;
    assign restore_ok = restore_valid_reg && !evt.stand_time_bad
                        && (evt.stand_time_sec <= restore_limit_reg);

    // Time since the current running session began; all differences wrap.
    assign session_elapsed = evt.now_ms - session_start_reg;
    // A moving tick restarts the idle clock before the timeout is checked.
    assign idle_eff     = active ? evt.now_ms : idle_start_reg;
    assign idle_elapsed = evt.now_ms - idle_eff;
    assign save_elapsed = evt.now_ms - last_save_reg;

    always_comb
    begin
        awaiting_next      = awaiting_reg;
        base_travel_next   = base_travel_reg;
        session_start_next = session_start_reg;
        idle_start_next    = idle_start_reg;
        last_save_next     = last_save_reg;
        stop_saved_next    = stop_saved_reg;
        running_next       = running_reg;
        travel_now_next    = travel_now_reg;
        res_next           = '0;

        case (evt.op)
            OP_BEGIN:
            begin
                travel_now_next    = '0;
                base_travel_next   = '0;
                session_start_next = evt.now_ms;
                idle_start_next    = evt.now_ms;
                running_next       = 1'b0;
                stop_saved_next    = 1'b0;
                last_save_next     = '0;
                awaiting_next      = 1'b1;
            end
            OP_REPORT:
            begin
                if (awaiting_reg)
                begin
                    res_next.handled   = 1'b1;
                    session_start_next = evt.now_ms;
                    idle_start_next    = evt.now_ms;
                    running_next       = 1'b0;
                    awaiting_next      = 1'b0;
                    if (restore_ok)
                    begin
                        travel_now_next   = restored_travel_reg;
                        base_travel_next  = restored_travel_reg;
                        res_next.restored = 1'b1;
                    end
                    else
                    begin
                        // Clear the trip without asking for a save.
                        travel_now_next       = '0;
                        base_travel_next      = '0;
                        stop_saved_next       = 1'b0;
                        last_save_next        = '0;
                        res_next.trip_cleared = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (!awaiting_reg)
                begin
                    if (active)
                    begin
                        if (!running_reg)
                        begin
                            session_start_next = evt.now_ms;
                            running_next       = 1'b1;
                            travel_now_next    = base_travel_reg;
                        end
                        else
                        begin
                            travel_now_next = base_travel_reg + session_elapsed;
                        end
                        idle_start_next = evt.now_ms;
                    end
                    else
                    begin
                        if (running_reg)
                        begin
                            base_travel_next = base_travel_reg + session_elapsed;
                            travel_now_next  = base_travel_reg + session_elapsed;
                            running_next     = 1'b0;
                        end
                        else
                        begin
                            travel_now_next = base_travel_reg;
                        end
                    end

                    if (!stopped)
                    begin
                        stop_saved_next = 1'b0;
                        last_save_next  = '0;
                    end
                    else
                    begin
                        if (!stop_saved_reg || (save_elapsed >= save_interval_reg))
                        begin
                            res_next.save_stopped = 1'b1;
                            stop_saved_next       = 1'b1;
                            last_save_next        = evt.now_ms;
                        end
                        if (idle_elapsed >= timeout_ms_reg)
                        begin
                            // Idle too long: clear the trip and save it cleared.
                            travel_now_next       = '0;
                            base_travel_next      = '0;
                            session_start_next    = evt.now_ms;
                            idle_start_next       = evt.now_ms;
                            running_next          = 1'b0;
                            stop_saved_next       = 1'b0;
                            last_save_next        = '0;
                            res_next.trip_cleared = 1'b1;
                            res_next.save_cleared = 1'b1;
                            res_next.handled      = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // The unused code leaves the state alone.
            end
        endcase

        res_next.travel_time_ms  = travel_now_next;
        res_next.awaiting_report = awaiting_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_valid_reg   <= 1'b0;
            restored_travel_reg <= '0;
            stop_speed_reg      <= STOP_SPEED_RST;
            save_speed_reg      <= SAVE_SPEED_RST;
            fuel_threshold_reg  <= FUEL_THRESHOLD_RST;
            timeout_ms_reg      <= TIMEOUT_MS_RST;
            restore_limit_reg   <= RESTORE_LIMIT_SEC_RST;
            save_interval_reg   <= SAVE_INTERVAL_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESTORE_VALID:   restore_valid_reg   <= cfg_data[0];
                REG_RESTORED_TRAVEL: restored_travel_reg <= cfg_data;
                REG_STOP_SPEED:      stop_speed_reg      <= cfg_data[15:0];
                REG_SAVE_SPEED:      save_speed_reg      <= cfg_data[15:0];
                REG_FUEL_THRESHOLD:  fuel_threshold_reg  <= cfg_data[15:0];
                REG_TIMEOUT:         timeout_ms_reg      <= cfg_data;
                REG_RESTORE_LIMIT:   restore_limit_reg   <= cfg_data;
                REG_SAVE_INTERVAL:   save_interval_reg   <= cfg_data;
                default:             restore_valid_reg   <= restore_valid_reg;
            endcase
        end
    end

    // Trip state, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg      <= 1'b1;
            base_travel_reg   <= '0;
            session_start_reg <= '0;
            idle_start_reg    <= '0;
            last_save_reg     <= '0;
            stop_saved_reg    <= 1'b0;
            running_reg       <= 1'b0;
            travel_now_reg    <= '0;
        end
        else if (evt_accept)
        begin
            awaiting_reg      <= awaiting_next;
            base_travel_reg   <= base_travel_next;
            session_start_reg <= session_start_next;
            idle_start_reg    <= idle_start_next;
            last_save_reg     <= last_save_next;
            stop_saved_reg    <= stop_saved_next;
            running_reg       <= running_next;
            travel_now_reg    <= travel_now_next;
        end
    end

    // Output register: loads on every accepted item, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (evt_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // A begin always leaves the trip empty and waiting for the report.
    a_begin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        evt_accept && (evt.op == OP_BEGIN)
        |=> awaiting_reg && res_valid && res.awaiting_report && (res.travel_time_ms == '0))
        else $error("begin did not leave the block waiting with an empty trip");

    // A report taken while waiting is always resolved and ends the wait.
    a_report_resolves: assert property (@(posedge clk) disable iff (!rst_n)
        evt_accept && (evt.op == OP_REPORT) && awaiting_reg
        |=> !awaiting_reg && res.handled && (res.restored != res.trip_cleared))
        else $error("report while waiting was not resolved exactly one way");

    // A tick while waiting changes nothing and raises no flag.
    a_tick_waiting_idle: assert property (@(posedge clk) disable iff (!rst_n)
        evt_accept && (evt.op == OP_TICK) && awaiting_reg
        |=> awaiting_reg && !res.handled && !res.trip_cleared && !res.save_stopped
            && ($past(travel_now_reg) == travel_now_reg))
        else $error("tick while waiting changed the trip");
`endif

endmodule
